FILE: design/bounded_id_set_table_assert.svh
// ---------------------------------------------------------------------------
// bounded_id_set_table_assert.svh
// Assertion macros shared by the id set table modules.
// ---------------------------------------------------------------------------
`ifndef BOUNDED_ID_SET_TABLE_ASSERT_SVH
`define BOUNDED_ID_SET_TABLE_ASSERT_SVH

// Check that a condition holds at every rising clock edge outside reset.
`define IDSET_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("id set table: invariant violated");

// Check that a trigger is followed in the next cycle by a consequence.
`define IDSET_ASSERT_NEXT(label, clk, rst, trig, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
      else $error("id set table: sequence violated");

// Check that a trigger implies a condition in the same cycle.
`define IDSET_ASSERT_IMPLY(label, clk, rst, trig, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
      else $error("id set table: implication violated");

`endif

FILE: design/idset_pkg.sv
// ---------------------------------------------------------------------------
// idset_pkg
// Field widths, operation and status codes, and the command and status
// groups exchanged between the id set controller and its datapath.
// ---------------------------------------------------------------------------
package idset_pkg;

   localparam int ID_W     = 32;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 2;
   localparam int FILL_W   = 9;

   // Operation codes; the unused code behaves as a lookup
   localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] STAT_DONE   = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_DUP    = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_ABSENT = 2'd3;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;    // latch the request word, restart the scan
      logic scan;    // issue one read and compare one entry
      logic shift;   // move one entry down by one slot
      logic finish;  // commit the table update and load the response
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic scan_done;
      logic scan_hit;
      logic shift_done;
      logic is_remove;
      logic out_free;
   } stat_type;

endpackage

FILE: design/bounded_id_set_table.sv
// ---------------------------------------------------------------------------
// bounded_id_set_table
// Packed set of up to CAPACITY 32-bit identifiers with lookup, insert and
// remove; one response word per request word.
// ---------------------------------------------------------------------------
//   channel  | direction | handshake             | payload
//   req_     | in        | req_valid / req_ready | mode, ident
//   rsp_     | out       | rsp_valid / rsp_ready | found, status, fill_count
//
// One request at a time; the single entry memory read port scans and then
// compacts one entry per cycle.
// Synchronous reset empties the table at once; no clearing pass is needed.
// A stalled response is held in the output register; the next request is
// taken meanwhile and waits at its commit step until that register frees.
// ---------------------------------------------------------------------------
module bounded_id_set_table
   import idset_pkg::*;
#(
   parameter int CAPACITY = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [ID_W-1:0]     req_ident,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_found,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [FILL_W-1:0]   rsp_fill_count
);

   cmd_type  cmd;
   stat_type stat;

   // Sequencer
   idset_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Table storage and compare
   idset_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_mode       (req_mode),
      .req_ident      (req_ident),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_found      (rsp_found),
      .rsp_status     (rsp_status),
      .rsp_fill_count (rsp_fill_count)
   );

endmodule

FILE: design/idset_ctrl.sv
// ---------------------------------------------------------------------------
// idset_ctrl
// Sequencer for the id set table: takes a request word, walks the scan,
// the optional compaction shift and the commit step.
// ---------------------------------------------------------------------------
`include "bounded_id_set_table_assert.svh"

module idset_ctrl
   import idset_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_SHIFT  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);

   // Decode commands and next state
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               if (stat.scan_hit && stat.is_remove) begin
                  state_in = ST_SHIFT;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SHIFT: begin
            cmd.shift = 1'b1;
            if (stat.shift_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the response register can take the word
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `IDSET_ASSERT_NEXT(a_accept_scans, clock, reset, req_valid && req_ready, state_ff == ST_SCAN)
   `IDSET_ASSERT_IMPLY(a_finish_free, clock, reset, cmd.finish, stat.out_free)
   `IDSET_ASSERT_NEXT(a_shift_only_remove, clock, reset,
      state_ff == ST_SCAN && state_in == ST_SHIFT, stat.is_remove)

endmodule

FILE: design/idset_dp.sv
// ---------------------------------------------------------------------------
// idset_dp
// Datapath of the id set table: entry memory, fill count, scan and shift
// index counters, comparator and the response register.
// ---------------------------------------------------------------------------
`include "bounded_id_set_table_assert.svh"

module idset_dp
   import idset_pkg::*;
#(
   parameter int CAPACITY = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [ID_W-1:0]     req_ident,
   input  cmd_type             cmd,
   output stat_type            stat,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_found,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [FILL_W-1:0]   rsp_fill_count
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int AW    = $clog2(CAPACITY);
   localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

   // Entry memory, no reset; only slots below the count are ever read
   logic [ID_W-1:0] mem [CAPACITY];

   logic [ID_W-1:0]     key_ff;
   logic [MODE_W-1:0]   mode_ff;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                rd_valid_ff, rd_valid_in;
   logic [ID_W-1:0]     rdata_ff;
   logic                hit_ff, hit_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff;
   logic [STATUS_W-1:0] rsp_status_ff, res_status;
   logic [FILL_W-1:0]   rsp_fill_ff;

   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [ID_W-1:0]     wr_data;
   logic                more;
   logic                match;
   logic [CNT_W-1:0]    prev_idx;
   logic [CNT_W+FILL_W-1:0] cnt_ext;

   assign more     = (idx_ff < count_ff);
   assign match    = rd_valid_ff && (rdata_ff == key_ff);
   assign prev_idx = rd_idx_ff - ONE_C;
   assign rd_addr  = idx_ff[AW-1:0];

   assign stat.scan_hit   = match;
   assign stat.scan_done  = match || (!rd_valid_ff && !more);
   assign stat.shift_done = !rd_valid_ff && !more;
   assign stat.is_remove  = (mode_ff == MODE_REMOVE);
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   // Step the scan and shift pipelines
   always_comb begin
      idx_in      = idx_ff;
      rd_idx_in   = rd_idx_ff;
      rd_valid_in = rd_valid_ff;
      hit_in      = hit_ff;
      rd_en       = 1'b0;
      if (cmd.load) begin
         idx_in      = '0;
         rd_valid_in = 1'b0;
         hit_in      = 1'b0;
      end else if (cmd.scan || cmd.shift) begin
         rd_en       = more;
         rd_valid_in = more;
         rd_idx_in   = idx_ff;
         if (more) begin
            idx_in = idx_ff + ONE_C;
         end
         // on a hit, park the pipeline and aim the shift past the match
         if (cmd.scan && match) begin
            hit_in      = 1'b1;
            idx_in      = rd_idx_ff + ONE_C;
            rd_valid_in = 1'b0;
         end
      end
   end

   // Decide the outcome and the table update
   always_comb begin
      count_in   = count_ff;
      res_status = STAT_ABSENT;
      wr_en      = 1'b0;
      wr_addr    = prev_idx[AW-1:0];
      wr_data    = rdata_ff;
      if (cmd.shift && rd_valid_ff) begin
         wr_en = 1'b1;
      end
      case (mode_ff)
         MODE_INSERT: begin
            if (count_ff >= CAP_C) begin
               res_status = STAT_FULL;
            end else if (hit_ff) begin
               res_status = STAT_DUP;
            end else begin
               res_status = STAT_DONE;
               if (cmd.finish) begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[AW-1:0];
                  wr_data  = key_ff;
                  count_in = count_ff + ONE_C;
               end
            end
         end
         MODE_REMOVE: begin
            if (hit_ff) begin
               res_status = STAT_DONE;
               if (cmd.finish) begin
                  count_in = count_ff - ONE_C;
               end
            end
         end
         default: begin
            res_status = hit_ff ? STAT_DONE : STAT_ABSENT;
         end
      endcase
   end

   assign cnt_ext      = {{FILL_W{1'b0}}, count_in};
   assign rsp_valid_in = cmd.finish ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // Memory ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff  <= req_ident;
         mode_ff <= req_mode;
      end
      idx_ff    <= idx_in;
      rd_idx_ff <= rd_idx_in;
      hit_ff    <= hit_in;
      if (cmd.finish) begin
         rsp_found_ff  <= hit_ff;
         rsp_status_ff <= res_status;
         rsp_fill_ff   <= cnt_ext[FILL_W-1:0];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_fill_count = rsp_fill_ff;

   `IDSET_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CAP_C)
   `IDSET_ASSERT_IMPLY(a_shift_addr, clock, reset,
      cmd.shift && rd_valid_ff, rd_idx_ff != '0 && rd_idx_ff < count_ff)
   `IDSET_ASSERT_IMPLY(a_read_in_range, clock, reset, rd_en, idx_ff < count_ff)

endmodule

FILE: tb/sv/bounded_id_set_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Id set table checker
// Watches the request and response channels of the id set table, keeps its
// own copy of the packed table and fill count, and compares every response
// word field by field with the oldest predicted outcome.
// ----------------------------------------------------------------------------
module bounded_id_set_table_checker
   import idset_pkg::*;
#(
   parameter int CAPACITY = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [ID_W-1:0]     req_ident,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic                rsp_found,
   input  logic [STATUS_W-1:0] rsp_status,
   input  logic [FILL_W-1:0]   rsp_fill_count,
   output int                  pending_words,
   output int                  mismatch_count
);

   typedef struct packed {
      logic                found;
      logic [STATUS_W-1:0] status;
      logic [FILL_W-1:0]   fill;
   } outcome_type;

   logic [ID_W-1:0] model_ids [CAPACITY];
   int              model_fill;
   outcome_type     pending_outcomes [$];

   initial begin
      pending_words  = 0;
      mismatch_count = 0;
      model_fill     = 0;
   end

   // Print one line and count the failure
   task automatic report_mismatch(string what, longint got, longint want);
      $display("[%0t] id set mismatch: %s got 0x%0h expected 0x%0h", $realtime, what, got,
               want);
      mismatch_count++;
   endtask

   // Apply one request word to the local table and return its outcome
   function automatic outcome_type apply_id_op(logic [MODE_W-1:0] mode,
                                               logic [ID_W-1:0] ident);
      outcome_type res;
      int          pos;
      logic        hit;
      pos = -1;
      for (int k = 0; k < model_fill; k++) begin
         if (model_ids[k] == ident) begin
            pos = k;
            break;
         end
      end
      hit = (pos >= 0);
      case (mode)
         MODE_INSERT: begin
            // Full check wins over the duplicate check
            if (model_fill >= CAPACITY) begin
               res.status = STAT_FULL;
            end else if (hit) begin
               res.status = STAT_DUP;
            end else begin
               model_ids[model_fill] = ident;
               model_fill++;
               res.status = STAT_DONE;
            end
         end
         MODE_REMOVE: begin
            // Drop the first match and pack the tail down
            if (hit) begin
               for (int k = pos; k + 1 < model_fill; k++) begin
                  model_ids[k] = model_ids[k + 1];
               end
               model_fill--;
               res.status = STAT_DONE;
            end else begin
               res.status = STAT_ABSENT;
            end
         end
         default: begin
            // Lookup, and the spare code that behaves as one
            res.status = hit ? STAT_DONE : STAT_ABSENT;
         end
      endcase
      res.found = hit;
      res.fill  = FILL_W'(model_fill);
      return res;
   endfunction

   // Predict on each accepted request, compare on each accepted response
   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         model_fill = 0;
         pending_outcomes.delete();
      end else begin
         if (req_valid && req_ready) begin
            pending_outcomes.push_back(apply_id_op(req_mode, req_ident));
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_outcomes.size() == 0) begin
               report_mismatch("response with none pending",
                               {rsp_found, rsp_status, rsp_fill_count}, 0);
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_found !== want.found)
                  report_mismatch("found", rsp_found, want.found);
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_fill_count !== want.fill)
                  report_mismatch("fill_count", rsp_fill_count, want.fill);
            end
         end
      end
      pending_words <= pending_outcomes.size();
   end

endmodule

FILE: tb/sv/bounded_id_set_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Id set table testbench
// Drives lookup, insert and remove words into the id set table in bursts,
// stalls the response side on its own pattern, fills the table to capacity
// and drains it again; a separate checker predicts and compares responses.
// ----------------------------------------------------------------------------
module bounded_id_set_table_tb;
   import idset_pkg::*;

   localparam int              CAPACITY    = 256;
   localparam int              CYCLE_LIMIT = 2000000;
   localparam int              HOLD_CYCLES = 3000;
   localparam int              TAIL_CYCLES = 600;
   // Spare operation code, handled by the block as a lookup
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

   logic                clock;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_ready;
   logic [MODE_W-1:0]   req_mode       = MODE_LOOKUP;
   logic [ID_W-1:0]     req_ident      = '0;
   logic                rsp_valid;
   logic                rsp_ready      = 1'b0;
   logic                rsp_found;
   logic [STATUS_W-1:0] rsp_status;
   logic [FILL_W-1:0]   rsp_fill_count;

   int                  pending_words;
   int                  mismatch_count;
   int                  cycle_count    = 0;
   int                  burst_left     = 0;
   logic [ID_W-1:0]     known_ids [$];

   bounded_id_set_table #(.CAPACITY(CAPACITY)) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_ident      (req_ident),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_found      (rsp_found),
      .rsp_status     (rsp_status),
      .rsp_fill_count (rsp_fill_count)
   );

   bounded_id_set_table_checker #(.CAPACITY(CAPACITY)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_ident      (req_ident),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_found      (rsp_found),
      .rsp_status     (rsp_status),
      .rsp_fill_count (rsp_fill_count),
      .pending_words  (pending_words),
      .mismatch_count (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Pick an id seen before, or a fresh one when none is known yet
   function automatic logic [ID_W-1:0] pick_known();
      if (known_ids.size() == 0)
         return $urandom;
      return known_ids[$urandom_range(known_ids.size() - 1)];
   endfunction

   // Offer one word; open a new burst after a gap when the last one ran out
   task automatic issue_word(logic [MODE_W-1:0] mode, logic [ID_W-1:0] ident);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(4) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
         gap        = $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_ident <= ident;
      do @(posedge clock); while (!req_ready);
      burst_left--;
   endtask

   // Hold the sender until every predicted response has come back
   task automatic wait_all_answered();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_words != 0);
   endtask

   // Response side: stall on a segment pattern, with one long hold-off
   initial begin : rsp_side
      int   seg_left;
      int   duty;
      int   taken;
      logic hold_done;
      seg_left  = 0;
      duty      = 100;
      taken     = 0;
      hold_done = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (!hold_done && taken >= 40) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (seg_left == 0) begin
            seg_left = $urandom_range(8, 64);
            case ($urandom_range(3))
               0:       duty = 100;
               1:       duty = 80;
               2:       duty = 40;
               default: duty = 10;
            endcase
         end
         rsp_ready <= ($urandom_range(99) < duty);
         seg_left--;
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            taken++;
      end
   end

   // Request side: directed words, then fill, full, drain and mixed phases
   initial begin : req_side
      logic [ID_W-1:0] id;
      int              idx;
      int              pick;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Empty table, extreme ids, duplicates, shifts and the spare code
      issue_word(MODE_LOOKUP, 32'h0000_0000);
      issue_word(MODE_REMOVE, 32'h0000_0000);
      issue_word(MODE_SPARE,  32'hFFFF_FFFF);
      issue_word(MODE_INSERT, 32'h0000_0000);
      issue_word(MODE_INSERT, 32'hFFFF_FFFF);
      issue_word(MODE_INSERT, 32'h0000_0000);
      issue_word(MODE_INSERT, 32'h5A5A_5A5A);
      issue_word(MODE_INSERT, 32'hA5A5_A5A5);
      issue_word(MODE_INSERT, 32'h8000_0000);
      issue_word(MODE_LOOKUP, 32'h0000_0000);
      issue_word(MODE_SPARE,  32'hA5A5_A5A5);
      issue_word(MODE_REMOVE, 32'h5A5A_5A5A);
      issue_word(MODE_LOOKUP, 32'h5A5A_5A5A);
      issue_word(MODE_LOOKUP, 32'h8000_0000);
      issue_word(MODE_REMOVE, 32'h0000_0000);
      issue_word(MODE_REMOVE, 32'h8000_0000);
      issue_word(MODE_REMOVE, 32'h8000_0000);
      issue_word(MODE_INSERT, 32'h5A5A_5A5A);
      issue_word(MODE_REMOVE, 32'hFFFF_FFFF);
      issue_word(MODE_REMOVE, 32'hA5A5_A5A5);
      issue_word(MODE_REMOVE, 32'h5A5A_5A5A);
      issue_word(MODE_SPARE,  32'h0000_0001);
      issue_word(MODE_INSERT, 32'h0000_0001);
      known_ids.push_back(32'h0000_0001);
      wait_all_answered();

      // Fill to capacity, mostly fresh inserts, with some overflow at the end
      for (int i = 0; i < 300; i++) begin
         if (i % 16 == 7) begin
            issue_word(($urandom_range(1) != 0) ? MODE_LOOKUP : MODE_SPARE, pick_known());
         end else if (i % 16 == 11) begin
            issue_word(MODE_INSERT, pick_known());
         end else begin
            id = $urandom;
            known_ids.push_back(id);
            issue_word(MODE_INSERT, id);
         end
      end
      wait_all_answered();

      // Stay at the full mark: refused inserts, lookups, remove and refill
      for (int i = 0; i < 60; i++) begin
         pick = $urandom_range(99);
         if (pick < 25) begin
            issue_word(MODE_INSERT, $urandom);
         end else if (pick < 50) begin
            issue_word(MODE_INSERT, pick_known());
         end else if (pick < 70) begin
            issue_word(MODE_LOOKUP, pick_known());
         end else if (pick < 85) begin
            issue_word(MODE_REMOVE, pick_known());
         end else begin
            id = $urandom;
            known_ids.push_back(id);
            issue_word(MODE_INSERT, id);
         end
      end
      wait_all_answered();

      // Drain: remove known ids, with some misses and lookups mixed in
      for (int i = 0; i < 320; i++) begin
         pick = $urandom_range(99);
         if (pick < 85 && known_ids.size() > 0) begin
            idx = $urandom_range(known_ids.size() - 1);
            id  = known_ids[idx];
            known_ids.delete(idx);
            issue_word(MODE_REMOVE, id);
         end else if (pick < 93) begin
            issue_word(MODE_REMOVE, $urandom);
         end else begin
            issue_word(MODE_LOOKUP, pick_known());
         end
      end
      wait_all_answered();

      // Mixed: small id space so hits, duplicates and shifts come often
      for (int i = 0; i < 150; i++) begin
         id = $urandom_range(15);
         if ($urandom_range(3) == 0)
            id = id | 32'hFFFF_FFF0;
         issue_word(MODE_W'($urandom_range(3)), id);
      end
      wait_all_answered();

      // Let any stray response show up, then give the verdict
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_words == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+design
design/idset_pkg.sv
design/idset_ctrl.sv
design/idset_dp.sv
design/bounded_id_set_table.sv
tb/sv/bounded_id_set_table_checker.sv
tb/sv/bounded_id_set_table_tb.sv
